// File: design/nfcs_pkg.sv
// Shared types, opcodes and sizes for the NOR flash command sequencer.
// No dependencies; every module of the block imports this package.

package nfcs_pkg;

	localparam int PAGE_BYTES   = 256;
	localparam int SECTOR_BYTES = 65536;
	localparam int PAGE_W       = $clog2(PAGE_BYTES);
	localparam int SECTOR_W     = $clog2(SECTOR_BYTES);
	localparam int MAX_RES      = 4;
	localparam int CNT_W        = $clog2(MAX_RES + 1);
	localparam int RD_W         = $clog2(MAX_RES);

	localparam logic [31:0] POLL_LIMIT_RESET = 32'd3000000;

	// Request kinds carried in tuser of the input stream.
	localparam logic [2:0] KIND_PROGRAM = 3'd0;
	localparam logic [2:0] KIND_ERASE   = 3'd1;
	localparam logic [2:0] KIND_READ    = 3'd2;
	localparam logic [2:0] KIND_READ_ID = 3'd3;
	localparam logic [2:0] KIND_STATUS  = 3'd4;

	// Result actions.
	localparam logic ACT_CMD    = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	// Operation of a multi-unit request.
	localparam logic OPER_PROGRAM = 1'b0;
	localparam logic OPER_ERASE   = 1'b1;

	// Flash opcodes and status bits.
	localparam logic [7:0] OP_NONE    = 8'h00;
	localparam logic [7:0] OP_READ_ID = 8'h9F;
	localparam logic [7:0] OP_WREN    = 8'h06;
	localparam logic [7:0] OP_RDSR1   = 8'h05;
	localparam logic [7:0] OP_RDSR2   = 8'h07;
	localparam logic [7:0] OP_CLSR    = 8'h30;
	localparam logic [7:0] OP_READ4   = 8'h13;
	localparam logic [7:0] OP_PP4     = 8'h12;
	localparam logic [7:0] OP_SE4     = 8'hDC;
	localparam logic [7:0] WIP_BIT    = 8'h01;
	localparam logic [7:0] E_ERR_BIT  = 8'h40;
	localparam logic [7:0] P_ERR_BIT  = 8'h20;

	typedef struct packed {
		logic        action;
		logic [7:0]  opcode;
		logic [31:0] flash_address;
		logic        has_address;
		logic [8:0]  write_len;
		logic [31:0] data_offset;
		logic [31:0] read_len;
		logic        failed;
	} res_t;

	// All results caused by one input item, in order, plus how many are used.
	typedef struct packed {
		res_t [MAX_RES-1:0] items;
		logic [CNT_W-1:0]   count;
	} group_t;

	function automatic res_t mk_res(input logic act, input logic [7:0] opc,
			input logic [31:0] addr, input logic has, input logic [8:0] wlen,
			input logic [31:0] off, input logic [31:0] rlen, input logic fail);
		res_t r;
		r.action        = act;
		r.opcode        = opc;
		r.flash_address = addr;
		r.has_address   = has;
		r.write_len     = wlen;
		r.data_offset   = off;
		r.read_len      = rlen;
		r.failed        = fail;
		return r;
	endfunction

endpackage

// File: design/nfcs_core.sv
// Sequencer state and the single-pass decision logic for one input item.
// Depends on nfcs_pkg for opcodes, sizes and the result group type.

module nfcs_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [2:0]           kind,
	input  logic [31:0]          address,
	input  logic [31:0]          length,
	input  logic [7:0]           status_byte,
	input  logic [31:0]          poll_limit,
	output nfcs_pkg::group_t     group
);
	import nfcs_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_POLL  = 2'd1;
	localparam logic [1:0] PH_CHECK = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic        oper_q, oper_d;
	logic [32:0] next_q, next_d;
	logic [32:0] end_q, end_d;
	logic [8:0]  chunk_q, chunk_d;
	logic [31:0] src_q, src_d;
	logic [31:0] polls_q, polls_d;

	// Unit (page chunk or sector) logic, shared by request start and continuation.
	logic        from_req;
	logic [32:0] req_sum, req_end, aligned;
	logic [32:0] unit_next, unit_end, rest, unit_after;
	logic        unit_oper;
	logic [31:0] unit_off, src_acc;
	logic [PAGE_W:0] room;
	logic [8:0]  unit_chunk;
	logic [31:0] poll_eff, polls_dec;

	assign from_req  = (kind == KIND_PROGRAM) || (kind == KIND_ERASE);
	assign req_sum   = {1'b0, address} + {1'b0, length};
	// An end beyond the address space is cut to its top so commands never wrap.
	assign req_end   = (req_sum[32] && (req_sum[31:0] != 32'd0)) ? {1'b1, 32'd0} : req_sum;
	assign aligned   = {1'b0, address[31:SECTOR_W], {SECTOR_W{1'b0}}};
	assign unit_oper = from_req ? kind[0] : oper_q;
	assign unit_next = from_req ? ((kind == KIND_PROGRAM) ? {1'b0, address} : aligned)
	                            : next_q;
	assign unit_end  = from_req ? req_end : end_q;
	assign src_acc   = src_q + ((oper_q == OPER_PROGRAM) ? {23'd0, chunk_q} : 32'd0);
	assign unit_off  = from_req ? 32'd0 : src_acc;
	assign rest      = unit_end - unit_next;
	assign room      = (PAGE_W + 1)'(PAGE_BYTES) - {1'b0, unit_next[PAGE_W-1:0]};
	assign unit_chunk = (rest < 33'(room)) ? rest[8:0] : 9'(room);
	assign unit_after = (unit_oper == OPER_ERASE) ? unit_next + 33'(SECTOR_BYTES)
	                                              : unit_next + {24'd0, unit_chunk};
	assign poll_eff  = (poll_limit == 32'd0) ? 32'd1 : poll_limit;
	assign polls_dec = polls_q - 32'd1;

	always_comb begin
		logic [CNT_W-1:0] n;
		logic             do_unit;
		logic [7:0]       mask;
		n        = '0;
		do_unit  = 1'b0;
		mask     = (oper_q == OPER_PROGRAM) ? P_ERR_BIT : E_ERR_BIT;
		group    = '0;
		phase_d  = phase_q;
		oper_d   = oper_q;
		next_d   = next_q;
		end_d    = end_q;
		chunk_d  = chunk_q;
		src_d    = src_q;
		polls_d  = polls_q;
		if (kind < KIND_STATUS && phase_q != PH_IDLE) begin
			group.items[n[RD_W-1:0]] = mk_res(ACT_FINISH, OP_NONE, 32'd0, 1'b0, 9'd0,
				32'd0, 32'd0, 1'b1);
			n = n + 1'b1;
		end else begin
			case (kind)
				KIND_PROGRAM, KIND_ERASE: begin
					if (length == 32'd0) begin
						group.items[n[RD_W-1:0]] = mk_res(ACT_FINISH, OP_NONE, 32'd0, 1'b0,
							9'd0, 32'd0, 32'd0, 1'b0);
						n = n + 1'b1;
					end else begin
						oper_d  = kind[0];
						end_d   = req_end;
						do_unit = 1'b1;
					end
				end
				KIND_READ: begin
					group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_READ4, address, 1'b1, 9'd0,
						32'd0, length, 1'b0);
					n = n + 1'b1;
					group.items[n[RD_W-1:0]] = mk_res(ACT_FINISH, OP_NONE, 32'd0, 1'b0, 9'd0,
						32'd0, 32'd0, 1'b0);
					n = n + 1'b1;
				end
				KIND_READ_ID: begin
					group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_READ_ID, 32'd0, 1'b0, 9'd0,
						32'd0, 32'd3, 1'b0);
					n = n + 1'b1;
					group.items[n[RD_W-1:0]] = mk_res(ACT_FINISH, OP_NONE, 32'd0, 1'b0, 9'd0,
						32'd0, 32'd0, 1'b0);
					n = n + 1'b1;
				end
				KIND_STATUS: begin
					if (phase_q == PH_POLL) begin
						if ((status_byte & WIP_BIT) == 8'd0) begin
							group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_RDSR2, 32'd0, 1'b0,
								9'd0, 32'd0, 32'd1, 1'b0);
							n = n + 1'b1;
							phase_d = PH_CHECK;
						end else begin
							polls_d = polls_dec;
							if (polls_dec == 32'd0) begin
								phase_d = PH_IDLE;
								group.items[n[RD_W-1:0]] = mk_res(ACT_FINISH, OP_NONE, 32'd0,
									1'b0, 9'd0, 32'd0, 32'd0, 1'b1);
							end else begin
								group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_RDSR1, 32'd0,
									1'b0, 9'd0, 32'd0, 32'd1, 1'b0);
							end
							n = n + 1'b1;
						end
					end else if (phase_q == PH_CHECK) begin
						group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_CLSR, 32'd0, 1'b0, 9'd0,
							32'd0, 32'd0, 1'b0);
						n = n + 1'b1;
						if ((status_byte & mask) != 8'd0) begin
							phase_d = PH_IDLE;
							group.items[n[RD_W-1:0]] = mk_res(ACT_FINISH, OP_NONE, 32'd0, 1'b0,
								9'd0, 32'd0, 32'd0, 1'b1);
							n = n + 1'b1;
						end else begin
							src_d = src_acc;
							if (next_q < end_q) begin
								do_unit = 1'b1;
							end else begin
								phase_d = PH_IDLE;
								group.items[n[RD_W-1:0]] = mk_res(ACT_FINISH, OP_NONE, 32'd0,
									1'b0, 9'd0, 32'd0, 32'd0, 1'b0);
								n = n + 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (do_unit) begin
			group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_WREN, 32'd0, 1'b0, 9'd0, 32'd0,
				32'd0, 1'b0);
			n = n + 1'b1;
			if (unit_oper == OPER_PROGRAM) begin
				group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_PP4, unit_next[31:0], 1'b1,
					unit_chunk, unit_off, 32'd0, 1'b0);
				chunk_d = unit_chunk;
			end else begin
				group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_SE4, unit_next[31:0], 1'b1,
					9'd0, 32'd0, 32'd0, 1'b0);
			end
			n = n + 1'b1;
			group.items[n[RD_W-1:0]] = mk_res(ACT_CMD, OP_RDSR1, 32'd0, 1'b0, 9'd0, 32'd0,
				32'd1, 1'b0);
			n = n + 1'b1;
			if (from_req) begin
				src_d   = 32'd0;
			end
			next_d  = unit_after;
			polls_d = poll_eff;
			phase_d = PH_POLL;
		end
		group.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			oper_q  <= OPER_PROGRAM;
			next_q  <= '0;
			end_q   <= '0;
			chunk_q <= '0;
			src_q   <= '0;
			polls_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			oper_q  <= oper_d;
			next_q  <= next_d;
			end_q   <= end_d;
			chunk_q <= chunk_d;
			src_q   <= src_d;
			polls_q <= polls_d;
		end
	end

	// While a unit is in flight the poll budget is never exhausted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_POLL) |-> (polls_q != 32'd0))
		else $error("poll counter empty while polling");

	// The unused phase code, outside the three named phases, is never reached.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) || (phase_q == PH_POLL) || (phase_q == PH_CHECK))
		else $error("sequencer phase corrupted");

	// The end address never goes beyond the top of the address space.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (end_q <= {1'b1, 32'd0}))
		else $error("end address beyond address space");

endmodule

// File: design/nfcs_outbuf.sv
// Result buffer: holds one input item's results, sends one per cycle unless stalled.
// Depends on nfcs_pkg for the result and group types.

module nfcs_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  nfcs_pkg::group_t  group,
	output logic              free,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output nfcs_pkg::res_t    res,
	output logic              m_axis_tlast
);
	import nfcs_pkg::*;

	res_t [MAX_RES-1:0] items_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RD_W-1:0]    rd_q;
	logic               xfer;

	assign m_axis_tvalid = (cnt_q != '0);
	assign res           = items_q[rd_q];
	assign m_axis_tlast  = ({1'b0, rd_q} == cnt_q - 1'b1);
	assign xfer          = m_axis_tvalid && m_axis_tready;
	// The buffer takes a new group once its last result leaves.
	assign free          = (cnt_q == '0) || (xfer && m_axis_tlast);

	always_ff @(posedge clk) begin
		if (load) begin
			items_q <= group.items;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= group.count;
			rd_q  <= '0;
		end else if (xfer) begin
			if (m_axis_tlast) begin
				cnt_q <= '0;
				rd_q  <= '0;
			end else begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result group loaded over pending results");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> ({1'b0, rd_q} < cnt_q))
		else $error("read pointer past result count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && m_axis_tlast && !load) |=> !m_axis_tvalid)
		else $error("results continue after last transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RES))
		else $error("result count too large");

endmodule

// File: design/nor_flash_command_sequencer.sv
// Top level of the NOR flash command sequencer: input register, configuration
// register, and the nfcs_core and nfcs_outbuf blocks. Depends on nfcs_pkg.
//
// Usage: requests (program, erase, read, read ID) and status bytes read back
// from the flash enter on the s_axis stream, kind in tuser. For each transfer
// the block sends zero to four results on the m_axis stream; tuser tells a
// command descriptor from a finished item and tlast marks the final result of
// the input. Inputs that cause no result are consumed silently.
// The first result of an input passes the input register and the result buffer
// before it leaves. Results leave one per cycle while the receiver is ready; the
// single four-entry result buffer holds one input's results. A new input is taken
// while earlier results are still draining. When the receiver stalls, the buffer
// holds its results and the input register fills, then s_axis_tready drops.
// Reset clears the sequencer to idle, empties the buffer and loads poll_limit
// with 3000000. cfg_we writes poll_limit; write it only while the block is idle.

module nor_flash_command_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [71:0]   s_axis_tdata,   // address[31:0], length[63:32], status_byte[71:64]
	input  logic [2:0]    s_axis_tuser,   // kind
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [119:0]  m_axis_tdata,   // opcode, flash_address, has_address, write_len,
	                                      // data_offset, read_len, failed, zero fill
	output logic [0:0]    m_axis_tuser,   // action
	output logic          m_axis_tlast
);
	import nfcs_pkg::*;

	logic        valid_s1;
	logic [2:0]  kind_s1;
	logic [31:0] address_s1;
	logic [31:0] length_s1;
	logic [7:0]  status_s1;
	logic [31:0] poll_limit_q;
	logic        load;
	logic        free;
	group_t      group;
	res_t        res;

	assign load          = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RESET;
		end else if (cfg_we) begin
			poll_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1    <= s_axis_tuser;
			address_s1 <= s_axis_tdata[31:0];
			length_s1  <= s_axis_tdata[63:32];
			status_s1  <= s_axis_tdata[71:64];
		end
	end

	nfcs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (load),
		.kind        (kind_s1),
		.address     (address_s1),
		.length      (length_s1),
		.status_byte (status_s1),
		.poll_limit  (poll_limit_q),
		.group       (group)
	);

	nfcs_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.group         (group),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.res           (res),
		.m_axis_tlast  (m_axis_tlast)
	);

	assign m_axis_tuser = res.action;
	assign m_axis_tdata = {5'd0, res.failed, res.read_len, res.data_offset, res.write_len,
	                       res.has_address, res.flash_address, res.opcode};

endmodule

// File: sim/tb.sv
// Self-checking testbench for nor_flash_command_sequencer: drives requests and status bytes,
// predicts every command descriptor and finished item, and checks the result stream.
// Depends on nfcs_pkg and the RTL of the block.

module tb;
	import nfcs_pkg::*;

	localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
	localparam logic [32:0] ADDR_TOP = 33'h1_0000_0000;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_POLL,
		SEQ_CHECK
	} seq_phase_t;

	typedef struct {
		res_t cmd;
		logic last;
	} flash_cmd_t;

	class cmd_scoreboard;
		logic [31:0] poll_limit;
		seq_phase_t seq_phase;
		logic oper;
		logic [32:0] next_addr;
		logic [32:0] end_addr;
		logic [8:0] chunk_len;
		logic [31:0] buf_offset;
		logic [31:0] polls_remaining;
		flash_cmd_t expected_cmds[$];
		flash_cmd_t staged;
		bit have_staged;
		int mismatches;

		function new();
			poll_limit = POLL_LIMIT_RESET;
			seq_phase = SEQ_IDLE;
			oper = OPER_PROGRAM;
			next_addr = '0;
			end_addr = '0;
			chunk_len = '0;
			buf_offset = '0;
			polls_remaining = '0;
			have_staged = 1'b0;
			mismatches = 0;
		endfunction

		// The newest command is held back so that the last one of a request can be marked.
		function void add_cmd(logic act, logic [7:0] opc, logic [31:0] addr, logic has,
				logic [8:0] wlen, logic [31:0] off, logic [31:0] rlen, logic fail);
			if (have_staged)
				expected_cmds.push_back(staged);
			staged.cmd.action = act;
			staged.cmd.opcode = opc;
			staged.cmd.flash_address = addr;
			staged.cmd.has_address = has;
			staged.cmd.write_len = wlen;
			staged.cmd.data_offset = off;
			staged.cmd.read_len = rlen;
			staged.cmd.failed = fail;
			staged.last = 1'b0;
			have_staged = 1'b1;
		endfunction

		function void finished(logic fail);
			add_cmd(ACT_FINISH, OP_NONE, '0, 1'b0, '0, '0, '0, fail);
		endfunction

		// Write enable, the page program or sector erase, and the first status-1 read.
		function void issue_unit();
			logic [32:0] room;
			logic [32:0] rest;
			logic [32:0] take;
			add_cmd(ACT_CMD, OP_WREN, '0, 1'b0, '0, '0, '0, 1'b0);
			if (oper == OPER_PROGRAM) begin
				room = 33'(PAGE_BYTES) - (next_addr % 33'(PAGE_BYTES));
				rest = end_addr - next_addr;
				take = (room < rest) ? room : rest;
				chunk_len = take[8:0];
				add_cmd(ACT_CMD, OP_PP4, next_addr[31:0], 1'b1, take[8:0], buf_offset, '0, 1'b0);
				next_addr = next_addr + take;
			end else begin
				add_cmd(ACT_CMD, OP_SE4, next_addr[31:0], 1'b1, '0, '0, '0, 1'b0);
				next_addr = next_addr + 33'(SECTOR_BYTES);
			end
			add_cmd(ACT_CMD, OP_RDSR1, '0, 1'b0, '0, '0, 32'd1, 1'b0);
			polls_remaining = (poll_limit == 0) ? 32'd1 : poll_limit;
			seq_phase = SEQ_POLL;
		endfunction

		function void note_request(logic [2:0] kind, logic [31:0] addr, logic [31:0] len,
				logic [7:0] st);
			logic [32:0] stop;
			logic [7:0] mask;
			have_staged = 1'b0;
			if (kind > KIND_STATUS)
				return;
			if (kind != KIND_STATUS && seq_phase != SEQ_IDLE) begin
				finished(1'b1);
			end else if (kind == KIND_PROGRAM || kind == KIND_ERASE) begin
				if (len == 0) begin
					finished(1'b0);
				end else begin
					stop = {1'b0, addr} + {1'b0, len};
					if (stop > ADDR_TOP)
						stop = ADDR_TOP;
					oper = (kind == KIND_ERASE) ? OPER_ERASE : OPER_PROGRAM;
					end_addr = stop;
					buf_offset = '0;
					chunk_len = '0;
					if (kind == KIND_PROGRAM)
						next_addr = {1'b0, addr};
					else
						next_addr = {1'b0, addr} - ({1'b0, addr} % 33'(SECTOR_BYTES));
					issue_unit();
				end
			end else if (kind == KIND_READ) begin
				add_cmd(ACT_CMD, OP_READ4, addr, 1'b1, '0, '0, len, 1'b0);
				finished(1'b0);
			end else if (kind == KIND_READ_ID) begin
				add_cmd(ACT_CMD, OP_READ_ID, '0, 1'b0, '0, '0, 32'd3, 1'b0);
				finished(1'b0);
			end else if (seq_phase == SEQ_POLL) begin
				if ((st & WIP_BIT) == 0) begin
					add_cmd(ACT_CMD, OP_RDSR2, '0, 1'b0, '0, '0, 32'd1, 1'b0);
					seq_phase = SEQ_CHECK;
				end else begin
					polls_remaining = polls_remaining - 1;
					if (polls_remaining == 0) begin
						seq_phase = SEQ_IDLE;
						finished(1'b1);
					end else begin
						add_cmd(ACT_CMD, OP_RDSR1, '0, 1'b0, '0, '0, 32'd1, 1'b0);
					end
				end
			end else if (seq_phase == SEQ_CHECK) begin
				mask = (oper == OPER_PROGRAM) ? P_ERR_BIT : E_ERR_BIT;
				add_cmd(ACT_CMD, OP_CLSR, '0, 1'b0, '0, '0, '0, 1'b0);
				if ((st & mask) != 0) begin
					seq_phase = SEQ_IDLE;
					finished(1'b1);
				end else begin
					if (oper == OPER_PROGRAM)
						buf_offset = buf_offset + 32'(chunk_len);
					if (next_addr < end_addr) begin
						issue_unit();
					end else begin
						seq_phase = SEQ_IDLE;
						finished(1'b0);
					end
				end
			end
			if (have_staged) begin
				staged.last = 1'b1;
				expected_cmds.push_back(staged);
				have_staged = 1'b0;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t mismatch in %s: expected %h actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic act, logic [119:0] data, logic lst);
			flash_cmd_t exp_cmd;
			if (expected_cmds.size() == 0) begin
				$display("%0t unexpected result: expected none, actual action %b data %h last %b",
					$time, act, data, lst);
				mismatches++;
				return;
			end
			exp_cmd = expected_cmds.pop_front();
			compare_field("action", 32'(exp_cmd.cmd.action), 32'(act));
			compare_field("opcode", 32'(exp_cmd.cmd.opcode), 32'(data[7:0]));
			compare_field("flash_address", exp_cmd.cmd.flash_address, data[39:8]);
			compare_field("has_address", 32'(exp_cmd.cmd.has_address), 32'(data[40]));
			compare_field("write_len", 32'(exp_cmd.cmd.write_len), 32'(data[49:41]));
			compare_field("data_offset", exp_cmd.cmd.data_offset, data[81:50]);
			compare_field("read_len", exp_cmd.cmd.read_len, data[113:82]);
			compare_field("failed", 32'(exp_cmd.cmd.failed), 32'(data[114]));
			compare_field("last", 32'(exp_cmd.last), 32'(lst));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [2:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [119:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic m_axis_tlast;

	cmd_scoreboard sb;
	bit tx_burst;
	bit rx_burst;
	bit rx_hold;
	int counted_items;

	nor_flash_command_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic send_item(input logic [2:0] kind, input logic [31:0] addr,
			input logic [31:0] len, input logic [7:0] st);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {st, len, addr};
		s_axis_tuser = kind;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		if (kind < KIND_STATUS || (kind == KIND_STATUS && sb.seq_phase != SEQ_IDLE))
			counted_items++;
		sb.note_request(kind, addr, len, st);
	endtask

	// Ends any open request, then waits for the result stream to run dry.
	task automatic drain();
		while (sb.seq_phase != SEQ_IDLE)
			send_item(KIND_STATUS, 32'd0, 32'd0,
				(sb.seq_phase == SEQ_POLL) ? 8'h00 : (P_ERR_BIT | E_ERR_BIT));
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.expected_cmds.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_poll_limit(input logic [31:0] value);
		drain();
		@(negedge clk);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.poll_limit = value;
	endtask

	// Answers status reads until the request ends, with busy polls, stray requests and
	// flash errors mixed in. The error is forced once max_units units have been done.
	task automatic finish_request(input int max_units);
		int units;
		int pick;
		logic [7:0] st;
		units = 0;
		while (sb.seq_phase != SEQ_IDLE) begin
			pick = $urandom_range(0, 99);
			st = 8'($urandom);
			if (pick < 4) begin
				send_item(3'($urandom_range(0, 3)), $urandom, $urandom, st);
			end else if (pick < 7) begin
				send_item(3'($urandom_range(5, 7)), $urandom, $urandom, st);
			end else if (sb.seq_phase == SEQ_POLL) begin
				st[0] = ($urandom_range(0, 2) == 0);
				send_item(KIND_STATUS, $urandom, $urandom, st);
			end else begin
				units++;
				if ((units >= max_units && sb.next_addr < sb.end_addr)
						|| $urandom_range(0, 9) == 0)
					st = st | P_ERR_BIT | E_ERR_BIT;
				else if (sb.oper == OPER_PROGRAM)
					st = st & ~P_ERR_BIT;
				else
					st = st & ~E_ERR_BIT;
				send_item(KIND_STATUS, $urandom, $urandom, st);
			end
		end
	endtask

	task automatic random_sequence();
		int pick;
		logic [31:0] a;
		logic [31:0] l;
		pick = $urandom_range(0, 99);
		a = $urandom;
		l = $urandom;
		tx_burst = ($urandom_range(0, 3) == 0);
		if (pick < 40) begin
			if (pick < 34)
				l = $urandom_range(1, 700);
			else if (pick < 37)
				a[31:8] = '1;
			send_item(KIND_PROGRAM, a, l, 8'($urandom));
			finish_request($urandom_range(1, 4));
		end else if (pick < 68) begin
			if (pick < 62)
				l = $urandom_range(1, 200000);
			else if (pick < 65)
				a[31:16] = '1;
			send_item(KIND_ERASE, a, l, 8'($urandom));
			finish_request($urandom_range(1, 4));
		end else if (pick < 78) begin
			send_item(KIND_READ, a, l, 8'($urandom));
		end else if (pick < 85) begin
			send_item(KIND_READ_ID, a, l, 8'($urandom));
		end else if (pick < 89) begin
			send_item((pick % 2 == 0) ? KIND_PROGRAM : KIND_ERASE, a, 32'd0, 8'($urandom));
		end else if (pick < 93) begin
			send_item(KIND_STATUS, a, l, 8'($urandom));
		end else if (pick < 96) begin
			send_item(3'($urandom_range(5, 7)), a, l, 8'($urandom));
		end else begin
			// Short program near the top of the address space, which it may run into.
			a = 32'hFFFF_FFFF - $urandom_range(0, 600);
			send_item(KIND_PROGRAM, a, $urandom_range(1, 1200), 8'($urandom));
			finish_request(4);
		end
	endtask

	initial begin : result_sink
		int gap;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				m_axis_tready = 1'b0;
				repeat (200) @(negedge clk);
				rx_hold = 1'b0;
			end else begin
				if ($urandom_range(0, 31) == 0)
					rx_burst = !rx_burst;
				gap = rx_burst ? 0 : $urandom_range(0, 5);
				if (gap != 0) begin
					m_axis_tready = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			sb.check_result(m_axis_tuser[0], m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin
		#4000000;
		$display("FAIL nor_flash_command_sequencer");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] limits[5];
		int start;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_PROGRAM;
		m_axis_tready = 1'b0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		rx_hold = 1'b0;
		counted_items = 0;
		limits = '{32'd1, 32'd2, POLL_LIMIT_RESET, 32'hFFFF_FFFF, 32'd5};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reads at the field extremes, read ID, zero-length requests, ignored items.
		send_item(KIND_READ, 32'd0, 32'd0, 8'h00);
		send_item(KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_item(KIND_READ_ID, 32'd0, 32'd0, 8'h00);
		send_item(KIND_PROGRAM, 32'h0000_1234, 32'd0, 8'h00);
		send_item(KIND_ERASE, 32'hFFFF_FFFF, 32'd0, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'hFF);
		send_item(KIND_UNUSED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);

		// Program whose end is cut at the top of the address space.
		send_item(KIND_PROGRAM, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'h00);

		// Two-page program with a rejected request, an ignored kind, a busy poll
		// and a program error on the second page.
		send_item(KIND_PROGRAM, 32'h0000_01F0, 32'h0000_0020, 8'h00);
		send_item(KIND_READ, 32'h0000_0040, 32'd8, 8'h00);
		send_item(KIND_UNUSED_LO, 32'd0, 32'd0, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, WIP_BIT);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, P_ERR_BIT);

		// Erase of the last sector with a huge length, then an erase error.
		send_item(KIND_ERASE, 32'hFFFF_1234, 32'hFFFF_FFFF, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'h00);
		send_item(KIND_ERASE, 32'h0001_2345, 32'd1, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, E_ERR_BIT);

		// A poll limit of zero behaves as one: the first busy poll times out.
		write_poll_limit(32'd0);
		send_item(KIND_PROGRAM, 32'h0000_0100, 32'd1, 8'h00);
		send_item(KIND_STATUS, 32'd0, 32'd0, WIP_BIT);

		for (int p = 0; p < 5; p++) begin
			write_poll_limit(limits[p]);
			start = counted_items;
			if (p == 2) begin
				// Receiver stalls while reads arrive back to back, so the block fills up.
				rx_hold = 1'b1;
				tx_burst = 1'b1;
				repeat (10)
					send_item(KIND_READ, $urandom, $urandom, 8'($urandom));
			end
			while (counted_items - start < 16)
				random_sequence();
		end

		drain();
		if (sb.mismatches == 0 && sb.expected_cmds.size() == 0)
			$display("PASS nor_flash_command_sequencer");
		else
			$display("FAIL nor_flash_command_sequencer");
		$finish;
	end

endmodule
